// File: hdl/sxe_pkg.sv
package sxe_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int WORD_BITS_DEF = 32;

  // register numbers
  localparam logic [2:0] R_A = 3'd0;
  localparam logic [2:0] R_X = 3'd1;
  localparam logic [2:0] R_L = 3'd2;
  localparam logic [2:0] R_B = 3'd3;
  localparam logic [2:0] R_S = 3'd4;
  localparam logic [2:0] R_T = 3'd5;

  // condition codes
  localparam logic [1:0] CC_NONE = 2'd0;
  localparam logic [1:0] CC_LT   = 2'd1;
  localparam logic [1:0] CC_EQ   = 2'd2;
  localparam logic [1:0] CC_GT   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_RD   = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  localparam logic [15:0] INDEX_BASE = 16'd32767;
  localparam logic signed [31:0] RD_LIM_WORD = 32'sd16777215;
  localparam logic signed [31:0] RD_LIM_BYTE = 32'sd255;

  // opcodes
  localparam logic [7:0] OP_LDA  = 8'h00;
  localparam logic [7:0] OP_LDX  = 8'h04;
  localparam logic [7:0] OP_LDL  = 8'h08;
  localparam logic [7:0] OP_LDB  = 8'h68;
  localparam logic [7:0] OP_LDS  = 8'h6C;
  localparam logic [7:0] OP_LDT  = 8'h74;
  localparam logic [7:0] OP_STA  = 8'h0C;
  localparam logic [7:0] OP_STX  = 8'h10;
  localparam logic [7:0] OP_STL  = 8'h14;
  localparam logic [7:0] OP_STB  = 8'h78;
  localparam logic [7:0] OP_STS  = 8'h7C;
  localparam logic [7:0] OP_STT  = 8'h84;
  localparam logic [7:0] OP_LDCH = 8'h50;
  localparam logic [7:0] OP_STCH = 8'h54;
  localparam logic [7:0] OP_ADD  = 8'h18;
  localparam logic [7:0] OP_COMP = 8'h28;
  localparam logic [7:0] OP_TIX  = 8'h2C;
  localparam logic [7:0] OP_J    = 8'h3C;
  localparam logic [7:0] OP_JEQ  = 8'h30;
  localparam logic [7:0] OP_JGT  = 8'h34;
  localparam logic [7:0] OP_JLT  = 8'h38;
  localparam logic [7:0] OP_COMPR = 8'hA0;
  localparam logic [7:0] OP_ADDR = 8'h90;
  localparam logic [7:0] OP_SUBR = 8'h94;
  localparam logic [7:0] OP_MULR = 8'h98;
  localparam logic [7:0] OP_DIVR = 8'h9C;
  localparam logic [7:0] OP_RMO  = 8'hAC;
  localparam logic [7:0] OP_CLEAR = 8'hB4;
  localparam logic [7:0] OP_TIXR = 8'hB8;
  localparam logic [7:0] OP_RD   = 8'hEC;
  localparam logic [7:0] OP_WD   = 8'hED;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EXEC = 1'b1;

  typedef struct packed {
    logic               func;
    logic [15:0]        load_addr;
    logic [7:0]         load_byte;
    logic signed [31:0] console_value;
  } in_t;

  typedef struct packed {
    logic [15:0]        pc;
    logic signed [31:0] reg_a;
    logic [1:0]         cond_code;
    logic               display_valid;
    logic signed [31:0] display_value;
    logic               display_as_char;
    logic               halted;
    logic [1:0]         error_code;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch;
    logic       do_load;
    logic       rd_issue;
    logic       rd_capt;
    logic       src_data;
    logic [1:0] cnt;
    logic       rf_rd;
    logic       rf_sel;
    logic       wr_byte;
    logic       div_start;
    logic       div_step;
    logic       exec;
    logic       stop;
    logic       finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic func_exec;
    logic halted;
    logic pc_over;
    logic rd_need;
    logic wr_need;
    logic word_op;
    logic is_div;
    logic div_zero;
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic logic [1:0] cmp_cc(logic signed [31:0] a, logic signed [31:0] b);
    if (a < b) return CC_LT;
    if (a == b) return CC_EQ;
    return CC_GT;
  endfunction

endpackage

// File: hdl/sxe_ctrl.sv
module sxe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sxe_pkg::sts_t sts,
  output sxe_pkg::cmd_t cmd
);
  import sxe_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECIDE = 11'b00000000010,
    S_RD_A   = 11'b00000000100,
    S_RD_B   = 11'b00000001000,
    S_RR1    = 11'b00000010000,
    S_RR2    = 11'b00000100000,
    S_DECODE = 11'b00001000000,
    S_WR     = 11'b00010000000,
    S_DIV    = 11'b00100000000,
    S_EXEC   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] last, last_next;
  logic       src, src_next;

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    last_next  = last;
    src_next   = src;
    cmd        = '0;
    cmd.cnt      = cnt;
    cmd.src_data = src;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.func_exec) begin
          cmd.do_load = 1'b1;
          state_next  = S_DONE;
        end else if (sts.halted) begin
          state_next = S_DONE;
        end else if (sts.pc_over) begin
          cmd.stop   = 1'b1;
          state_next = S_DONE;
        end else begin
          cnt_next   = 2'd0;
          last_next  = 2'd2;
          src_next   = 1'b0;
          state_next = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_capt = 1'b1;
        if (cnt != last) begin
          cnt_next   = cnt + 2'd1;
          state_next = S_RD_A;
        end else if (!src) begin
          state_next = S_RR1;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_RR1: begin
        cmd.rf_rd  = 1'b1;
        cmd.rf_sel = 1'b0;
        state_next = S_RR2;
      end
      S_RR2: begin
        cmd.rf_rd  = 1'b1;
        cmd.rf_sel = 1'b1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        cnt_next  = 2'd0;
        last_next = sts.word_op ? 2'd2 : 2'd0;
        if (sts.rd_need) begin
          src_next   = 1'b1;
          state_next = S_RD_A;
        end else if (sts.wr_need) begin
          state_next = S_WR;
        end else if (sts.is_div && !sts.div_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_WR: begin
        cmd.wr_byte = 1'b1;
        if (cnt != last) cnt_next = cnt + 2'd1;
        else state_next = S_EXEC;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_EXEC;
        else cmd.div_step = 1'b1;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 2'd0;
      last  <= 2'd0;
      src   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      last  <= last_next;
      src   <= src_next;
    end
  end

  // an accepted word is finished exactly once before the next is taken
  a_accept_from_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DECIDE))
    else $error("accept outside idle");
  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("finish did not return to idle");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt <= last) && (last == 2'd0 || last == 2'd2))
    else $error("byte counter out of range");

endmodule

// File: hdl/sxe_datapath.sv
module sxe_datapath #(
  parameter int MEM_BYTES = sxe_pkg::MEM_BYTES_DEF,
  parameter int WORD_BITS = sxe_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  sxe_pkg::in_t  in_word,
  input  logic          cfg_valid,
  input  logic [15:0]   cfg_data,
  input  sxe_pkg::cmd_t cmd,
  output sxe_pkg::sts_t sts,
  input  logic          out_stall,
  output logic          out_valid,
  output sxe_pkg::out_t out_word
);
  import sxe_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = $clog2(MEM_BYTES);
  localparam int CW = $clog2(W + 1);

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q;

  in_t                 in_q;
  logic [15:0]         last_exec;
  logic signed [W-1:0] regs [8];
  logic [15:0]         pc;
  logic [1:0]          cc;
  logic                halted;
  logic [7:0]          ibyte [3];
  logic [7:0]          dbyte [3];
  logic signed [W-1:0] op1, op2, mul_q;
  logic                dsp_valid, dsp_char;
  logic signed [31:0]  dsp_value;
  logic [1:0]          err;
  logic                rd_need, wr_need, word_op;

  // divider
  logic [W-1:0]  dv_rem, dv_quo, dv_den;
  logic [CW-1:0] dv_cnt;
  logic [W:0]    dv_sh, dv_diff;

  logic [7:0]          opc;
  logic [15:0]         opnd, ea, raddr, waddr;
  logic [2:0]          r1, r2, ridx;
  logic signed [W-1:0] ra, rx, rs, mem_val, xinc, st_val, quot, remd, tix_b;
  logic signed [31:0]  mem32;
  logic [W-1:0]        op1_mag, op2_mag;

  assign opc  = ibyte[0];
  assign opnd = {ibyte[1], ibyte[2]};
  assign r1   = ibyte[1][2:0];
  assign r2   = ibyte[2][2:0];
  assign ra   = regs[R_A];
  assign rx   = regs[R_X];
  assign rs   = regs[R_S];
  assign xinc = rx + W'(1);

  // effective address, indexed at or above the base
  assign ea = (opnd >= INDEX_BASE) ? (opnd + rx[15:0] - INDEX_BASE) : opnd;
  assign raddr = (cmd.src_data ? ea : pc) + {14'd0, cmd.cnt};
  assign waddr = cmd.do_load ? in_q.load_addr : (ea + {14'd0, cmd.cnt});

  // little-endian 24-bit word, sign-extended
  assign mem32   = 32'(signed'({dbyte[2], dbyte[1], dbyte[0]}));
  assign mem_val = mem32[W-1:0];

  // store source
  always_comb begin
    case (opc)
      OP_STX:  st_val = rx;
      OP_STL:  st_val = regs[R_L];
      OP_STB:  st_val = regs[R_B];
      OP_STS:  st_val = rs;
      OP_STT:  st_val = regs[R_T];
      default: st_val = ra;
    endcase
  end

  // decode classes
  always_comb begin
    rd_need = 1'b0;
    wr_need = 1'b0;
    word_op = 1'b0;
    unique case (opc)
      OP_LDA, OP_LDX, OP_LDL, OP_LDB, OP_LDS, OP_LDT, OP_ADD, OP_COMP, OP_TIX: begin
        rd_need = 1'b1;
        word_op = 1'b1;
      end
      OP_LDCH: rd_need = 1'b1;
      OP_STA, OP_STX, OP_STL, OP_STB, OP_STS, OP_STT: begin
        wr_need = 1'b1;
        word_op = 1'b1;
      end
      OP_STCH: wr_need = 1'b1;
      default: ;
    endcase
  end

  assign sts.rd_need   = rd_need;
  assign sts.wr_need   = wr_need;
  assign sts.word_op   = word_op;
  assign sts.func_exec = (in_q.func == FUNC_EXEC);
  assign sts.halted    = halted;
  assign sts.pc_over   = (pc > last_exec);
  assign sts.is_div    = (opc == OP_DIVR);
  assign sts.div_zero  = (op2 == '0);
  assign sts.div_done  = (dv_cnt == '0);
  assign sts.out_busy  = out_valid && out_stall;

  // byte memory, one port
  always_ff @(posedge clk) begin
    if (cmd.do_load) mem[waddr[AW-1:0]] <= in_q.load_byte;
    else if (cmd.wr_byte) mem[waddr[AW-1:0]] <= st_val[8*cmd.cnt +: 8];
    if (cmd.rd_issue) mem_q <= mem[raddr[AW-1:0]];
  end

  // fetch buffers, operand capture, product
  assign ridx = cmd.rf_sel ? r2 : r1;
  always_ff @(posedge clk) begin
    if (cmd.latch) in_q <= in_word;
    if (cmd.rd_capt) begin
      if (cmd.src_data) dbyte[cmd.cnt] <= mem_q;
      else ibyte[cmd.cnt] <= mem_q;
    end
    if (cmd.rf_rd) begin
      if (cmd.rf_sel) op2 <= regs[ridx];
      else op1 <= regs[ridx];
    end
    mul_q <= op1 * op2;
  end

  // restoring divider on magnitudes
  assign op1_mag = op1[W-1] ? W'(-op1) : W'(op1);
  assign op2_mag = op2[W-1] ? W'(-op2) : W'(op2);
  assign dv_sh   = {dv_rem, dv_quo[W-1]};
  assign dv_diff = dv_sh - {1'b0, dv_den};
  assign quot    = (op1[W-1] ^ op2[W-1]) ? -signed'(dv_quo) : signed'(dv_quo);
  assign remd    = op1[W-1] ? -signed'(dv_rem) : signed'(dv_rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.div_start) begin
      dv_cnt <= CW'(W);
    end else if (cmd.div_step) begin
      dv_cnt <= dv_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_rem <= '0;
      dv_quo <= op1_mag;
      dv_den <= op2_mag;
    end else if (cmd.div_step) begin
      dv_rem <= dv_diff[W] ? dv_sh[W-1:0] : dv_diff[W-1:0];
      dv_quo <= {dv_quo[W-2:0], ~dv_diff[W]};
    end
  end

  // TIXR compares against the updated X when r1 names X
  assign tix_b = (r1 == R_X) ? xinc : op1;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      pc        <= '0;
      cc        <= CC_NONE;
      halted    <= 1'b0;
      last_exec <= '0;
      dsp_valid <= 1'b0;
      dsp_char  <= 1'b0;
      dsp_value <= '0;
      err       <= ERR_NONE;
    end else begin
      if (cfg_valid) last_exec <= cfg_data;
      if (cmd.latch) begin
        dsp_valid <= 1'b0;
        dsp_char  <= 1'b0;
        dsp_value <= '0;
        err       <= ERR_NONE;
      end
      if (cmd.stop) halted <= 1'b1;
      if (cmd.exec) begin
        pc <= pc + 16'd3;
        case (opc)
          OP_LDA:  regs[R_A] <= mem_val;
          OP_LDX:  regs[R_X] <= mem_val;
          OP_LDL:  regs[R_L] <= mem_val;
          OP_LDB:  regs[R_B] <= mem_val;
          OP_LDS:  regs[R_S] <= mem_val;
          OP_LDT:  regs[R_T] <= mem_val;
          OP_LDCH: regs[R_A] <= W'({24'd0, dbyte[0]});
          OP_ADD:  regs[R_A] <= ra + mem_val;
          OP_COMP: cc <= cmp_cc(32'(ra), 32'(mem_val));
          OP_TIX: begin
            regs[R_X] <= xinc;
            cc <= cmp_cc(32'(xinc), 32'(mem_val));
          end
          OP_J: pc <= opnd;
          OP_JEQ: if (cc == CC_EQ) pc <= opnd;
          OP_JGT: if (cc == CC_GT) pc <= opnd;
          OP_JLT: if (cc == CC_LT) pc <= opnd;
          OP_COMPR: cc <= cmp_cc(32'(op1), 32'(op2));
          OP_ADDR: regs[r2] <= op1 + op2;
          OP_SUBR: regs[r2] <= op1 - op2;
          OP_MULR: regs[r2] <= mul_q;
          OP_DIVR: begin
            if (op2 == '0) begin
              halted <= 1'b1;
              err    <= ERR_DIV0;
            end else begin
              regs[r2]  <= quot;
              regs[R_L] <= remd;
            end
          end
          OP_RMO:   regs[r2] <= op1;
          OP_CLEAR: regs[r2] <= '0;
          OP_TIXR: begin
            regs[R_X] <= xinc;
            cc <= cmp_cc(32'(xinc), 32'(tix_b));
          end
          OP_RD: begin
            if (rs == '0 || rs == W'(1)) begin
              if (in_q.console_value > ((rs == '0) ? RD_LIM_WORD : RD_LIM_BYTE)) begin
                halted <= 1'b1;
                err    <= ERR_RD;
              end else begin
                regs[R_A] <= in_q.console_value[W-1:0];
              end
            end
          end
          OP_WD: begin
            if (rs == '0 || rs == W'(1)) begin
              dsp_valid <= 1'b1;
              dsp_value <= 32'(ra);
            end else if (rs == W'(2)) begin
              dsp_valid <= 1'b1;
              dsp_char  <= 1'b1;
              dsp_value <= {24'd0, ra[7:0]};
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.pc              <= pc;
      out_word.reg_a           <= 32'(ra);
      out_word.cond_code       <= cc;
      out_word.display_valid   <= dsp_valid;
      out_word.display_value   <= dsp_value;
      out_word.display_as_char <= dsp_char;
      out_word.halted          <= halted;
      out_word.error_code      <= err;
    end
  end

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (err != ERR_NONE) |-> halted)
    else $error("error raised without halt");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared");
  a_no_exec_halted: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && $past(halted)) |-> (err != ERR_NONE))
    else $error("instruction executed while halted");

endmodule

// File: hdl/sic_xe_instruction_executor_unit.sv
// Channel  Direction  Handshake          Word
// in       input      in_valid/in_stall  in_word   (sxe_pkg::in_t)
// out      output     out_valid/out_stall out_word (sxe_pkg::out_t)
// cfg      input      cfg_valid/cfg_ready cfg_data (last executable address)
//
// A load word, and a step while halted or past the bound, shows its result
// without a fetch; an executed instruction first reads its three bytes, and
// word and byte loads and stores then use the same single byte port of the
// program memory, each byte read passing an issue and a capture state; DIVR
// also runs the radix-2 divider.
// One word is in work at a time; in_stall is low only when the sequencer idles,
// which it enters as the result is loaded.
// Synchronous reset clears registers, flags and PC; memory keeps its contents.
// A stalled result holds in the output register and blocks the next finish.
module sic_xe_instruction_executor_unit #(
  parameter int MEM_BYTES = sxe_pkg::MEM_BYTES_DEF,
  parameter int WORD_BITS = sxe_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sxe_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output sxe_pkg::out_t out_word,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import sxe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sxe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sxe_datapath #(
    .MEM_BYTES (MEM_BYTES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while busy");
  a_err_shows_halt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.error_code != ERR_NONE) |-> out_word.halted)
    else $error("error result not halted");
  a_display_no_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.display_valid) |-> (out_word.error_code == ERR_NONE))
    else $error("display with error");

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sxe_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  // shadow copy of the machine plus the queue of predicted result words
  class sxe_shadow;
    logic [7:0]  mem [65536];
    logic [31:0] rf [8];
    logic [15:0] pc;
    logic [1:0]  cc;
    bit          halt;
    logic [15:0] last;
    out_t        pending [$];
    int          errs;

    function new();
      foreach (rf[i]) rf[i] = '0;
      pc = '0; cc = CC_NONE; halt = 0; last = '0; errs = 0;
    endfunction

    function logic [31:0] rd_word(logic [15:0] ea);
      logic [7:0] hi;
      hi = mem[ea + 16'd2];
      return {{8{hi[7]}}, hi, mem[ea + 16'd1], mem[ea]};
    endfunction

    function void wr_word(logic [15:0] ea, logic [31:0] v);
      mem[ea] = v[7:0];
      mem[ea + 16'd1] = v[15:8];
      mem[ea + 16'd2] = v[23:16];
    endfunction

    function logic [1:0] order(logic [31:0] a, logic [31:0] b);
      if ($signed(a) < $signed(b)) return CC_LT;
      if (a == b) return CC_EQ;
      return CC_GT;
    endfunction

    // apply one accepted input word, queue the result it must produce
    function void note(in_t w);
      out_t o;
      logic [7:0] opc, b1, b2;
      logic [15:0] p, opnd, ea;
      logic [2:0] r1, r2;
      logic signed [31:0] lim;
      longint n, d, q, rm;
      o = '0;
      if (w.func == FUNC_LOAD) begin
        mem[w.load_addr] = w.load_byte;
      end else if (!halt) begin
        if (pc > last) begin
          halt = 1;
        end else begin
          p = pc;
          opc = mem[p]; b1 = mem[p + 16'd1]; b2 = mem[p + 16'd2];
          pc = p + 16'd3;
          opnd = {b1, b2};
          ea = (opnd >= INDEX_BASE) ? opnd + rf[R_X][15:0] - INDEX_BASE : opnd;
          r1 = b1[2:0]; r2 = b2[2:0];
          case (opc)
            OP_LDA: rf[R_A] = rd_word(ea);
            OP_LDX: rf[R_X] = rd_word(ea);
            OP_LDL: rf[R_L] = rd_word(ea);
            OP_LDB: rf[R_B] = rd_word(ea);
            OP_LDS: rf[R_S] = rd_word(ea);
            OP_LDT: rf[R_T] = rd_word(ea);
            OP_STA: wr_word(ea, rf[R_A]);
            OP_STX: wr_word(ea, rf[R_X]);
            OP_STL: wr_word(ea, rf[R_L]);
            OP_STB: wr_word(ea, rf[R_B]);
            OP_STS: wr_word(ea, rf[R_S]);
            OP_STT: wr_word(ea, rf[R_T]);
            OP_LDCH: rf[R_A] = {24'd0, mem[ea]};
            OP_STCH: mem[ea] = rf[R_A][7:0];
            OP_ADD: rf[R_A] = rf[R_A] + rd_word(ea);
            OP_COMP: cc = order(rf[R_A], rd_word(ea));
            OP_TIX: begin
              rf[R_X] = rf[R_X] + 32'd1;
              cc = order(rf[R_X], rd_word(ea));
            end
            OP_J: pc = opnd;
            OP_JEQ: if (cc == CC_EQ) pc = opnd;
            OP_JGT: if (cc == CC_GT) pc = opnd;
            OP_JLT: if (cc == CC_LT) pc = opnd;
            OP_COMPR: cc = order(rf[r1], rf[r2]);
            OP_ADDR: rf[r2] = rf[r1] + rf[r2];
            OP_SUBR: rf[r2] = rf[r1] - rf[r2];
            OP_MULR: rf[r2] = rf[r1] * rf[r2];
            OP_DIVR: begin
              n = $signed(rf[r1]); d = $signed(rf[r2]);
              if (d == 0) begin
                halt = 1; o.error_code = ERR_DIV0;
              end else begin
                q = n / d; rm = n % d;
                rf[r2] = q[31:0];
                rf[R_L] = rm[31:0];
              end
            end
            OP_RMO: rf[r2] = rf[r1];
            OP_CLEAR: rf[r2] = '0;
            OP_TIXR: begin
              rf[R_X] = rf[R_X] + 32'd1;
              cc = order(rf[R_X], rf[r1]);
            end
            OP_RD: if (rf[R_S] == 0 || rf[R_S] == 1) begin
              lim = (rf[R_S] == 0) ? RD_LIM_WORD : RD_LIM_BYTE;
              if (w.console_value > lim) begin
                halt = 1; o.error_code = ERR_RD;
              end else begin
                rf[R_A] = w.console_value;
              end
            end
            OP_WD: if (rf[R_S] == 0 || rf[R_S] == 1) begin
              o.display_valid = 1; o.display_value = rf[R_A];
            end else if (rf[R_S] == 2) begin
              o.display_valid = 1; o.display_value = {24'd0, rf[R_A][7:0]};
              o.display_as_char = 1;
            end
            default: ;
          endcase
        end
      end
      o.pc = pc; o.reg_a = rf[R_A]; o.cond_code = cc; o.halted = halt;
      pending.push_back(o);
    endfunction

    function void field(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
        errs++;
      end
    endfunction

    function void check(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result word %h", $time, got);
        errs++;
        return;
      end
      e = pending.pop_front();
      field("pc", e.pc, got.pc);
      field("reg_a", e.reg_a, got.reg_a);
      field("cond_code", e.cond_code, got.cond_code);
      field("display_valid", e.display_valid, got.display_valid);
      field("display_value", e.display_value, got.display_value);
      field("display_as_char", e.display_as_char, got.display_as_char);
      field("halted", e.halted, got.halted);
      field("error_code", e.error_code, got.error_code);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_word;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  sxe_shadow sh = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  logic [7:0] op_list [31] = '{OP_LDA, OP_LDX, OP_LDL, OP_LDB, OP_LDS, OP_LDT,
    OP_STA, OP_STX, OP_STL, OP_STB, OP_STS, OP_STT, OP_LDCH, OP_STCH, OP_ADD,
    OP_COMP, OP_TIX, OP_J, OP_JEQ, OP_JGT, OP_JLT, OP_COMPR, OP_ADDR, OP_SUBR,
    OP_MULR, OP_DIVR, OP_RMO, OP_CLEAR, OP_TIXR, OP_RD, OP_WD};

  sic_xe_instruction_executor_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: random stall, check each accepted word
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) sh.check(out_word);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      in_word <= '0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sh.note(w);
  endtask

  task automatic load(logic [15:0] a, logic [7:0] b);
    in_t w;
    w.func = FUNC_LOAD; w.load_addr = a; w.load_byte = b; w.console_value = $urandom;
    send(w);
  endtask

  task automatic put_word(logic [15:0] a, logic [31:0] v);
    load(a, v[7:0]);
    load(a + 16'd1, v[15:8]);
    load(a + 16'd2, v[23:16]);
  endtask

  // place an instruction at the predicted PC and execute it
  task automatic run_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2, logic [31:0] con);
    in_t w;
    logic [15:0] p;
    p = sh.pc;
    load(p, op);
    load(p + 16'd1, b1);
    load(p + 16'd2, b2);
    w.func = FUNC_EXEC; w.load_addr = 16'($urandom); w.load_byte = 8'($urandom);
    w.console_value = con;
    send(w);
  endtask

  task automatic drain();
    in_valid <= 0;
    in_word <= '0;
    while (sh.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    // return to address zero first so PC stays inside any new bound
    run_op(OP_J, 8'h00, 8'h00, $urandom);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sh.last = v;
  endtask

  // one random instruction, now and then an arbitrary opcode, that keeps the machine running
  task automatic rand_op();
    logic [7:0] op, b1, b2;
    logic [15:0] nxt, opnd, ea, tgt;
    logic [31:0] con, v;
    op = ($urandom_range(99) < 4) ? 8'($urandom) : op_list[$urandom_range(30)];
    b1 = 8'($urandom); b2 = 8'($urandom); con = $urandom;
    if ($urandom_range(15) == 0) {b1, b2} = $urandom_range(1) ? 16'd32767 : 16'hFFFF;
    nxt = sh.pc + 16'd3;
    if (nxt > sh.last) op = OP_J;
    if (op == OP_J || op == OP_JEQ || op == OP_JGT || op == OP_JLT) begin
      tgt = 16'($urandom_range(sh.last, 0));
      {b1, b2} = tgt;
    end
    if (op == OP_DIVR && sh.rf[b2[2:0]] == 0) op = OP_ADDR;
    if (op == OP_RD) begin
      if ($urandom_range(7) == 0) con = (sh.rf[R_S] == 1) ? 32'd255 : 32'd16777215;
      if ((sh.rf[R_S] == 0 && $signed(con) > RD_LIM_WORD) ||
          (sh.rf[R_S] == 1 && $signed(con) > RD_LIM_BYTE)) con[31] = 1;
    end
    // write the operand word before every memory read; interesting values now and then
    if (op inside {OP_LDA, OP_LDX, OP_LDL, OP_LDB, OP_LDS, OP_LDT, OP_ADD,
                   OP_COMP, OP_TIX, OP_LDCH}) begin
      opnd = {b1, b2};
      ea = (opnd >= INDEX_BASE) ? opnd + sh.rf[R_X][15:0] - INDEX_BASE : opnd;
      case ($urandom_range(7))
        0: v = 0;
        1: v = 1;
        2: v = 2;
        3: v = 32'hFFFFFF;
        4: v = 32'h7FFFFF;
        5: v = 32'h800000;
        6: v = sh.rf[R_A];
        default: v = $urandom;
      endcase
      put_word(ea, v);
    end
    run_op(op, b1, b2, con);
  endtask

  initial begin
    int i, ph;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // bound at zero: only address zero may execute
    drain();
    cfg_valid <= 1;
    cfg_data <= 16'd0;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sh.last = 16'd0;
    repeat (3) rand_op();
    set_limit(16'hFFFF);

    // directed: device I/O at the limits, numeric display
    run_op(OP_CLEAR, 8'h00, 8'h04, '0);
    run_op(OP_RD, 8'h00, 8'h00, 32'd16777215);
    run_op(OP_WD, 8'h00, 8'h00, '0);
    put_word(16'h3000, 32'd1);
    run_op(OP_LDS, 8'h30, 8'h00, '0);
    run_op(OP_RD, 8'h00, 8'h00, 32'd255);
    run_op(OP_WD, 8'h00, 8'h00, '0);
    run_op(OP_RD, 8'h00, 8'h00, 32'h80000000);

    // random phases with varying bound and handshake pressure
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      case (ph)
        2: set_limit(16'd300);
        5: set_limit(16'($urandom_range(65535, 20)));
        6: set_limit(16'd0);
        7: set_limit(16'hFFFF);
        default: ;
      endcase
      for (i = 0; i < 32; i++) rand_op();
    end

    // divide by zero halts; later steps show the frozen state, loads still land
    idle_pct = 13; stall_pct = 13;
    run_op(OP_CLEAR, 8'h00, 8'h05, '0);
    run_op(OP_DIVR, 8'h00, 8'h05, '0);
    run_op(OP_WD, 8'h00, 8'h00, $urandom);
    run_op(OP_RD, 8'h00, 8'h00, $urandom);

    drain();
    if (sh.errs == 0 && sh.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// File: sic_xe_instruction_executor_unit.f
hdl/sxe_pkg.sv
hdl/sxe_ctrl.sv
hdl/sxe_datapath.sv
hdl/sic_xe_instruction_executor_unit.sv
tb/tb.sv
